// ===== rtl/vrp_pkg.sv =====
`default_nettype none

package vrp_pkg;

	localparam int COORD_FRAC_BITS_DEF = 8;

	// angle to radians: pi in Q16.16, plus rounding terms of the two divides
	localparam logic [17:0] PI_Q16   = 18'd205887;
	localparam logic [20:0] PI7_Q16  = 21'd1441209;
	localparam logic [8:0]  RX_ROUND = 9'd180;
	localparam logic [10:0] RY_ROUND = 11'd1800;

	// exact reciprocal multipliers for the constant divides
	localparam int RX_SHIFT   = 37;
	localparam int RY_SHIFT   = 43;
	localparam int DIV3_SHIFT = 31;
	localparam longint unsigned RX_MAGIC_L = ((64'd1 << RX_SHIFT) + 64'd359) / 64'd360;
	localparam longint unsigned RY_MAGIC_L = ((64'd1 << RY_SHIFT) + 64'd3599) / 64'd3600;
	localparam longint unsigned DIV3_MAGIC_L = ((64'd1 << DIV3_SHIFT) + 64'd2) / 64'd3;
	localparam logic [28:0] RX_MAGIC   = 29'(RX_MAGIC_L);
	localparam logic [31:0] RY_MAGIC   = 32'(RY_MAGIC_L);
	localparam logic [29:0] DIV3_MAGIC = 30'(DIV3_MAGIC_L);

	localparam int ANG_R_W     = 20;
	localparam int TRIG_W      = 29;
	localparam int TRIG_STAGES = 4;
	localparam int QUO_W       = 17;
	localparam logic [16:0] ONE_Q16 = 17'd65536;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	typedef enum logic [2:0] {
		REG_CENTER_X = 3'd0,
		REG_CENTER_Y = 3'd1,
		REG_FOCAL    = 3'd2,
		REG_BIAS     = 3'd3,
		REG_SCALE    = 3'd4
	} reg_idx_t;

	localparam logic [11:0] CENTER_X_RST = 12'd512;
	localparam logic [11:0] CENTER_Y_RST = 12'd384;
	localparam logic [9:0]  FOCAL_RST    = 10'd200;
	localparam logic [7:0]  BIAS_RST     = 8'd4;
	localparam logic [9:0]  SCALE_RST    = 10'd120;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} vtx_t;

	typedef struct packed {
		logic valid;
		logic dbad;
		logic negx;
		logic negy;
		logic satx;
		logic saty;
	} side_t;

endpackage

`default_nettype wire

// ===== rtl/vrp_trig.sv =====
`default_nettype none

module vrp_trig (
	input  wire logic                                 clk,
	input  wire logic                                 en,
	input  wire logic [vrp_pkg::ANG_R_W-1:0]          r,
	output logic signed [vrp_pkg::TRIG_W-1:0]         cosine,
	output logic signed [vrp_pkg::TRIG_W-1:0]         sine
);
	import vrp_pkg::*;

	logic [ANG_R_W-1:0] r_s1, r_s2, r_s3;
	logic [39:0]        sq_s1;
	logic [23:0]        r2_s2, r2_s3;
	logic [43:0]        r3p_s2;
	logic [47:0]        r4p_s2;
	logic [56:0]        d6p_s3;
	logic [58:0]        d24p_s3;
	logic [23:0]        r2;

	assign r2 = sq_s1[39:16];

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1    <= r;
			sq_s1   <= 40'(r) * 40'(r);
			r_s2    <= r_s1;
			r2_s2   <= r2;
			r3p_s2  <= 44'(r2) * 44'(r_s1);
			r4p_s2  <= 48'(r2) * 48'(r2);
			r_s3    <= r_s2;
			r2_s3   <= r2_s2;
			// r3/6 as (r3>>1)/3, r4/24 as (r4>>3)/3
			d6p_s3  <= 57'(r3p_s2[43:17]) * 57'(DIV3_MAGIC);
			d24p_s3 <= 59'(r4p_s2[47:19]) * 59'(DIV3_MAGIC);
			cosine  <= TRIG_W'(ONE_Q16) - TRIG_W'(r2_s3[23:1])
				+ TRIG_W'(d24p_s3[58:DIV3_SHIFT]);
			sine    <= TRIG_W'(r_s3) - TRIG_W'(d6p_s3[56:DIV3_SHIFT]);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/vrp_divider.sv =====
`default_nettype none

module vrp_divider #(
	parameter int NUM_W = 61,
	parameter int DEN_W = 42,
	parameter int QUO_W = 17
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic      [QUO_W-1:0] quo
);

	// restoring division, one quotient bit per stage, msb first
	logic [NUM_W-1:0] rem_s [QUO_W-1];
	logic [DEN_W-1:0] den_s [QUO_W-1];
	logic [QUO_W-1:0] quo_s [QUO_W];

	for (genvar i = 0; i < QUO_W; i++) begin : g_stage
		localparam int B = QUO_W - 1 - i;
		logic [NUM_W-1:0] rem_p;
		logic [DEN_W-1:0] den_p;
		logic [QUO_W-1:0] quo_p;
		logic [NUM_W:0]   shifted;
		logic [NUM_W:0]   diff;

		if (i == 0) begin : g_first
			assign rem_p = num;
			assign den_p = den;
			assign quo_p = '0;
		end else begin : g_next
			assign rem_p = rem_s[i-1];
			assign den_p = den_s[i-1];
			assign quo_p = quo_s[i-1];
		end

		assign shifted = (NUM_W+1)'(den_p) << B;
		assign diff    = {1'b0, rem_p} - shifted;

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[i] <= diff[NUM_W] ? quo_p : (quo_p | (QUO_W'(1) << B));
			end
		end

		if (i < QUO_W - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[i] <= diff[NUM_W] ? rem_p : diff[NUM_W-1:0];
					den_s[i] <= den_p;
				end
			end
		end
	end

	assign quo = quo_s[QUO_W-1];

endmodule

`default_nettype wire

// ===== rtl/vertex_rotate_project.sv =====
// vertex_rotate_project: rotates a vertex about x, then y, and projects it;
// throughput one vertex per cycle unless a result waits; angle, trig, rotation
// and divisor stages, 17 divider stages of one quotient bit each, output register
// the whole pipeline holds while a result waits under screen_stall
// arst_n clears all valid bits and loads the register reset values
`default_nettype none

module vertex_rotate_project #(
	parameter int COORD_FRAC_BITS = vrp_pkg::COORD_FRAC_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          vertex_valid,
	output logic                               vertex_stall,
	input  wire logic [9:0]                    angle_half_deg,
	input  wire logic signed [15:0]            vertex_x,
	input  wire logic signed [15:0]            vertex_y,
	input  wire logic signed [15:0]            vertex_z,
	output logic                               screen_valid,
	input  wire logic                          screen_stall,
	output logic signed [15:0]                 screen_x,
	output logic signed [15:0]                 screen_y,
	output logic                               clipped,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [vrp_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [vrp_pkg::DATA_W-1:0]    pwdata,
	output logic      [vrp_pkg::DATA_W-1:0]    prdata,
	output logic                               pready
);
	import vrp_pkg::*;

	localparam int PAD  = 16 - COORD_FRAC_BITS;
	localparam int CW   = 32 - COORD_FRAC_BITS;
	localparam int Y1W  = CW + 10;
	localparam int X2W  = CW + 18;
	localparam int DW1  = CW + 19;
	localparam int DW   = CW + 18;
	localparam int NW   = CW + 37;
	localparam int PW1  = CW + TRIG_W;
	localparam int PW2  = Y1W + TRIG_W;
	localparam int NXW  = X2W + 21;
	localparam int NYW  = Y1W + 21;

	// configuration registers
	logic [11:0] center_x_q, center_y_q;
	logic [9:0]  focal_q, scale_q;
	logic [7:0]  bias_q;
	logic [19:0] gain_q;
	logic        wr_en;
	reg_idx_t    idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= CENTER_X_RST;
			center_y_q <= CENTER_Y_RST;
			focal_q    <= FOCAL_RST;
			bias_q     <= BIAS_RST;
			scale_q    <= SCALE_RST;
			gain_q     <= 20'(FOCAL_RST) * 20'(SCALE_RST);
		end else begin
			gain_q <= 20'(focal_q) * 20'(scale_q);
			if (wr_en) begin
				unique case (idx)
					REG_CENTER_X: center_x_q <= pwdata[11:0];
					REG_CENTER_Y: center_y_q <= pwdata[11:0];
					REG_FOCAL:    focal_q    <= pwdata[9:0];
					REG_BIAS:     bias_q     <= pwdata[7:0];
					REG_SCALE:    scale_q    <= pwdata[9:0];
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		unique case (idx)
			REG_CENTER_X: prdata = DATA_W'(center_x_q);
			REG_CENTER_Y: prdata = DATA_W'(center_y_q);
			REG_FOCAL:    prdata = DATA_W'(focal_q);
			REG_BIAS:     prdata = DATA_W'(bias_q);
			REG_SCALE:    prdata = DATA_W'(scale_q);
			default:      prdata = '0;
		endcase
	end

	// pipeline advance
	logic adv;
	assign adv          = !screen_valid || !screen_stall;
	assign vertex_stall = !adv;

	logic [13:1] vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[12:1], vertex_valid};
		end
	end

	// angle to radians
	logic [27:0] n1_s1;
	logic [30:0] n2_s1;
	logic [56:0] p1_s2;
	logic [62:0] p2_s2;
	vtx_t        vtx_s1, vtx_s2, vtx_s3, vtx_s4, vtx_s5, vtx_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			n1_s1  <= 28'(angle_half_deg) * 28'(PI_Q16) + 28'(RX_ROUND);
			n2_s1  <= 31'(angle_half_deg) * 31'(PI7_Q16) + 31'(RY_ROUND);
			p1_s2  <= 57'(n1_s1) * 57'(RX_MAGIC);
			p2_s2  <= 63'(n2_s1) * 63'(RY_MAGIC);
			vtx_s1 <= '{x: vertex_x, y: vertex_y, z: vertex_z};
			vtx_s2 <= vtx_s1;
			vtx_s3 <= vtx_s2;
			vtx_s4 <= vtx_s3;
			vtx_s5 <= vtx_s4;
			vtx_s6 <= vtx_s5;
		end
	end

	logic signed [TRIG_W-1:0] cx, sx, cy, sy;

	vrp_trig u_trig_x (
		.clk    (clk),
		.en     (adv),
		.r      (p1_s2[RX_SHIFT +: ANG_R_W]),
		.cosine (cx),
		.sine   (sx)
	);

	vrp_trig u_trig_y (
		.clk    (clk),
		.en     (adv),
		.r      (p2_s2[RY_SHIFT +: ANG_R_W]),
		.cosine (cy),
		.sine   (sy)
	);

	// rotation about x, then about y
	logic signed [CW-1:0]     xw, yw, zw;
	logic signed [PW1-1:0]    yc_s7, zs_s7, ys_s7, zc_s7;
	logic signed [CW-1:0]     xw_s7, xw_s8;
	logic signed [TRIG_W-1:0] cy_s7, sy_s7, cy_s8, sy_s8;
	logic signed [PW1:0]      ysum, zsum;
	logic signed [Y1W-1:0]    y1_s8, z1_s8, y1_s9, y1_s10;
	logic signed [PW2-1:0]    xc_s9, zs_s9, zc_s9, xs_s9;
	logic signed [PW2:0]      xsum2, zsum2;
	logic signed [X2W-1:0]    x2_s10, z2_s10;

	assign xw = {vtx_s6.x, {PAD{1'b0}}};
	assign yw = {vtx_s6.y, {PAD{1'b0}}};
	assign zw = {vtx_s6.z, {PAD{1'b0}}};

	assign ysum  = (PW1+1)'(yc_s7) - (PW1+1)'(zs_s7);
	assign zsum  = (PW1+1)'(ys_s7) + (PW1+1)'(zc_s7);
	assign xsum2 = (PW2+1)'(xc_s9) + (PW2+1)'(zs_s9);
	assign zsum2 = (PW2+1)'(zc_s9) - (PW2+1)'(xs_s9);

	always_ff @(posedge clk) begin
		if (adv) begin
			yc_s7  <= PW1'(yw) * PW1'(cx);
			zs_s7  <= PW1'(zw) * PW1'(sx);
			ys_s7  <= PW1'(yw) * PW1'(sx);
			zc_s7  <= PW1'(zw) * PW1'(cx);
			xw_s7  <= xw;
			cy_s7  <= cy;
			sy_s7  <= sy;
			// floor of the Q32.32 sum back to Q16.16
			y1_s8  <= ysum[16 +: Y1W];
			z1_s8  <= zsum[16 +: Y1W];
			xw_s8  <= xw_s7;
			cy_s8  <= cy_s7;
			sy_s8  <= sy_s7;
			xc_s9  <= PW2'(xw_s8) * PW2'(cy_s8);
			zs_s9  <= PW2'(z1_s8) * PW2'(sy_s8);
			zc_s9  <= PW2'(z1_s8) * PW2'(cy_s8);
			xs_s9  <= PW2'(xw_s8) * PW2'(sy_s8);
			y1_s9  <= y1_s8;
			x2_s10 <= xsum2[16 +: X2W];
			z2_s10 <= zsum2[16 +: X2W];
			y1_s10 <= y1_s9;
		end
	end

	// perspective divisor and numerators
	logic signed [DW1-1:0] d_s11;
	logic signed [NXW-1:0] numx_s11;
	logic signed [NYW-1:0] numy_s11;
	logic signed [27:0]    fb_q16;
	logic [NW-1:0]         magx_s12, magy_s12, magx_s13, magy_s13;
	logic                  negx_s12, negy_s12, dbad_s12;
	logic                  negx_s13, negy_s13, dbad_s13, satx_s13, saty_s13;
	logic [DW-1:0]         den_s12, den_s13;

	assign fb_q16 = $signed({1'b0, 11'(focal_q) + 11'(bias_q), 16'b0});

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s11    <= DW1'(fb_q16) + DW1'(z2_s10);
			numx_s11 <= NXW'(x2_s10) * NXW'($signed({1'b0, gain_q}));
			numy_s11 <= NYW'(y1_s10) * NYW'($signed({1'b0, gain_q}));
			negx_s12 <= numx_s11[NXW-1];
			negy_s12 <= numy_s11[NYW-1];
			magx_s12 <= NW'(numx_s11[NXW-1] ? -numx_s11 : numx_s11);
			magy_s12 <= NW'(numy_s11[NYW-1] ? -numy_s11 : numy_s11);
			dbad_s12 <= d_s11[DW1-1] || (d_s11 == '0);
			den_s12  <= d_s11[DW-1:0];
			// a quotient of 2^17 or more saturates whatever the centre
			satx_s13 <= magx_s12[NW-1:QUO_W] >= (NW-QUO_W)'(den_s12);
			saty_s13 <= magy_s12[NW-1:QUO_W] >= (NW-QUO_W)'(den_s12);
			magx_s13 <= magx_s12;
			magy_s13 <= magy_s12;
			den_s13  <= den_s12;
			negx_s13 <= negx_s12;
			negy_s13 <= negy_s12;
			dbad_s13 <= dbad_s12;
		end
	end

	logic [QUO_W-1:0] qx, qy;

	vrp_divider #(.NUM_W(NW), .DEN_W(DW), .QUO_W(QUO_W)) u_div_x (
		.clk (clk),
		.en  (adv),
		.num (magx_s13),
		.den (den_s13),
		.quo (qx)
	);

	vrp_divider #(.NUM_W(NW), .DEN_W(DW), .QUO_W(QUO_W)) u_div_y (
		.clk (clk),
		.en  (adv),
		.num (magy_s13),
		.den (den_s13),
		.quo (qy)
	);

	side_t side_in;
	side_t side_q [QUO_W];
	side_t side_last;

	assign side_in = '{valid: vld_s[13], dbad: dbad_s13, negx: negx_s13, negy: negy_s13,
		satx: satx_s13, saty: saty_s13};
	assign side_last = side_q[QUO_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QUO_W; i++) begin
				side_q[i] <= '0;
			end
		end else if (adv) begin
			side_q[0] <= side_in;
			for (int i = 1; i < QUO_W; i++) begin
				side_q[i] <= side_q[i-1];
			end
		end
	end

	// centre plus signed offset, saturated to 16 bits
	function automatic logic [16:0] place(input logic [11:0] centre,
		input logic [QUO_W-1:0] q, input logic neg, input logic big);
		logic signed [18:0] off;
		logic signed [18:0] v;
		logic [16:0]        res;
		off = neg ? -$signed({2'b0, q}) : $signed({2'b0, q});
		v   = $signed({7'b0, centre}) + off;
		priority if (big) begin
			res = neg ? {1'b1, 16'h8000} : {1'b1, 16'h7fff};
		end else if (v > 19'sd32767) begin
			res = {1'b1, 16'h7fff};
		end else if (v < -19'sd32768) begin
			res = {1'b1, 16'h8000};
		end else begin
			res = {1'b0, v[15:0]};
		end
		return res;
	endfunction

	logic [16:0]        px, py;
	logic               screen_valid_q, clipped_q;
	logic signed [15:0] screen_x_q, screen_y_q;

	assign px = place(center_x_q, qx, side_last.negx, side_last.satx);
	assign py = place(center_y_q, qy, side_last.negy, side_last.saty);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_valid_q <= 1'b0;
		end else if (adv) begin
			screen_valid_q <= side_last.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (side_last.dbad) begin
				screen_x_q <= $signed({4'b0, center_x_q});
				screen_y_q <= $signed({4'b0, center_y_q});
				clipped_q  <= 1'b1;
			end else begin
				screen_x_q <= px[15:0];
				screen_y_q <= py[15:0];
				clipped_q  <= px[16] || py[16];
			end
		end
	end

	assign screen_valid = screen_valid_q;
	assign screen_x     = screen_x_q;
	assign screen_y     = screen_y_q;
	assign clipped      = clipped_q;

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		vertex_stall |-> (screen_valid && screen_stall))
		else $error("input stalled with no waiting result");

	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[13] && !dbad_s13) |-> (den_s13 != '0))
		else $error("zero divisor entering the divider");

	a_bad_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && side_last.valid && side_last.dbad) |=>
		(clipped && screen_x == $signed({4'b0, center_x_q})))
		else $error("non-positive divisor not mapped to the centre");

	a_gain: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(wr_en) |-> (gain_q == 20'(focal_q) * 20'(scale_q)))
		else $error("gain out of step with focal and scale");

endmodule

`default_nettype wire
